>>> sv/sacf_pkg.sv
`default_nettype none
package sacf_pkg;

	localparam int ADDR_W = 32;
	localparam int TAG_W  = 21;
	localparam int OP_W   = 2;
	localparam int OWAY_W = 3;

	localparam logic [OP_W-1:0] OP_READ  = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
	localparam logic [OP_W-1:0] OP_FETCH = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]   opcode;
		logic [ADDR_W-1:0] address;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic [OWAY_W-1:0] way;
		logic              victim_dirty;
		logic [TAG_W-1:0]  victim_tag;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR  = 3'b001,
		ST_IDLE   = 3'b010,
		ST_LOOKUP = 3'b100
	} state_t;

endpackage
`default_nettype wire

>>> sv/sacf_dir_mem.sv
`default_nettype none
module sacf_dir_mem #(
	parameter int DEPTH  = 64,
	parameter int AW     = 6,
	parameter int DW     = 118
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

>>> sv/sacf_way_logic.sv
`default_nettype none
module sacf_way_logic import sacf_pkg::*; #(
	parameter int NUM_WAYS = 5,
	parameter int WAY_W    = 3,
	parameter int ENT_W    = TAG_W + 2,
	parameter int ROW_W    = NUM_WAYS * ENT_W + WAY_W
) (
	input  wire logic [ROW_W-1:0] row,
	input  wire logic [TAG_W-1:0] tag,
	input  wire logic             is_write,
	output logic      [ROW_W-1:0] new_row,
	output rsp_t                  rsp
);

	// Each way's entry is {dirty, valid, tag}; the fill pointer sits above the ways.
	logic [TAG_W-1:0] tags   [NUM_WAYS];
	logic             valids [NUM_WAYS];
	logic             dirtys [NUM_WAYS];
	logic [WAY_W-1:0] ptr;
	logic [WAY_W-1:0] fill_way;
	logic [WAY_W-1:0] next_ptr;
	logic [WAY_W-1:0] hit_way;
	logic             hit;

	always_comb begin
		for (int w = 0; w < NUM_WAYS; w++) begin
			tags[w]   = row[w*ENT_W +: TAG_W];
			valids[w] = row[w*ENT_W + TAG_W];
			dirtys[w] = row[w*ENT_W + TAG_W + 1];
		end
		ptr = row[ROW_W-1 -: WAY_W];
	end

	// The lowest matching way wins, as ways are searched in order.
	always_comb begin
		hit     = 1'b0;
		hit_way = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (valids[w] && tags[w] == tag) begin
				hit     = 1'b1;
				hit_way = WAY_W'(w);
			end
		end
	end

	// The bound is compared as an integer so that a power-of-two way count
	// does not wrap to zero in the pointer's width.
	always_comb begin
		fill_way = (int'(ptr) >= NUM_WAYS) ? '0 : ptr;
		next_ptr = (fill_way == WAY_W'(NUM_WAYS - 1)) ? '0 : fill_way + WAY_W'(1);
	end

	always_comb begin
		new_row = row;
		rsp     = '0;
		if (hit) begin
			rsp.hit = 1'b1;
			rsp.way = OWAY_W'(hit_way);
			if (is_write) begin
				new_row[int'(hit_way)*ENT_W + TAG_W + 1] = 1'b1;
			end
		end else begin
			rsp.way = OWAY_W'(fill_way);
			if (valids[fill_way]) begin
				rsp.victim_dirty = dirtys[fill_way];
				rsp.victim_tag   = tags[fill_way];
			end
			new_row[int'(fill_way)*ENT_W +: ENT_W] = {is_write, 1'b1, tag};
			new_row[ROW_W-1 -: WAY_W] = next_ptr;
		end
	end

endmodule
`default_nettype wire

>>> sv/set_assoc_cache_fifo_lookup.sv
// Channel   Handshake              Payload  Notes
// request   start & !busy          req      opcode, byte address
// result    valid (one cycle)      rsp      hit, way, victim dirty and tag
//
// In an access, the set's row is read from the directory RAM
// at the accepting edge, and compared, updated and written back at the next.
// The result shows for one cycle after that, while the next access may start.
// After reset the block sweeps all NUM_SETS sets of the RAM, clearing valid,
// dirty and fill pointer state one set per cycle, with busy high.
// Results cannot be stalled; the receiver must take each one as it appears.
`default_nettype none
module set_assoc_cache_fifo_lookup import sacf_pkg::*; #(
	parameter int NUM_SETS   = 64,
	parameter int NUM_WAYS   = 5,
	parameter int LINE_BYTES = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire req_t req,
	output logic      valid,
	output rsp_t      rsp
);

	localparam int OFF_W = $clog2(LINE_BYTES);
	localparam int SET_W = $clog2(NUM_SETS);
	localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int ENT_W = TAG_W + 2;
	localparam int ROW_W = NUM_WAYS * ENT_W + WAY_W;

	state_t state_q;
	logic [SET_W-1:0] clr_cnt_q;
	logic [SET_W-1:0] set_s1;
	logic [TAG_W-1:0] tag_s1;
	logic             write_s1;
	logic             accept;
	logic [SET_W-1:0] req_set;
	logic [ADDR_W-1:0] line_tag;
	logic             mem_we;
	logic [SET_W-1:0] mem_waddr;
	logic [ROW_W-1:0] mem_wdata;
	logic [ROW_W-1:0] row;
	logic [ROW_W-1:0] new_row;
	rsp_t             rsp_d;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign req_set  = req.address[OFF_W +: SET_W];
	assign line_tag = req.address >> (OFF_W + SET_W);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = set_s1;
		mem_wdata = new_row;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
				mem_wdata = '0;
			end
			ST_LOOKUP: begin
				mem_we = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	sacf_dir_mem #(
		.DEPTH (NUM_SETS),
		.AW    (SET_W),
		.DW    (ROW_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (accept),
		.raddr (req_set),
		.rdata (row)
	);

	sacf_way_logic #(
		.NUM_WAYS (NUM_WAYS),
		.WAY_W    (WAY_W),
		.ENT_W    (ENT_W),
		.ROW_W    (ROW_W)
	) u_way (
		.row      (row),
		.tag      (tag_s1),
		.is_write (write_s1),
		.new_row  (new_row),
		.rsp      (rsp_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			valid     <= 1'b0;
		end else begin
			valid <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + SET_W'(1);
					if (clr_cnt_q == SET_W'(NUM_SETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					valid   <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			set_s1   <= req_set;
			tag_s1   <= line_tag[TAG_W-1:0];
			write_s1 <= (req.opcode == OP_WRITE);
		end
		if (state_q == ST_LOOKUP) begin
			rsp <= rsp_d;
		end
	end

endmodule
`default_nettype wire

>>> test/sacf_checker.sv
`timescale 1ns / 100ps

module sacf_checker import sacf_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic busy,
	input  req_t      req,
	input  wire logic valid,
	input  rsp_t      rsp,
	output int        errors,
	output int        pending,
	output int        results,
	output int        hits,
	output int        writebacks
);

	localparam int SETS = 64;
	localparam int WAYS = 5;

	logic [TAG_W-1:0]  dir_tag   [SETS][WAYS];
	logic              dir_valid [SETS][WAYS];
	logic              dir_dirty [SETS][WAYS];
	logic [OWAY_W-1:0] fill_ptr  [SETS];

	rsp_t expected_q[$];
	rsp_t want;

	// Looks up one access in the shadow directory and applies its update.
	function automatic rsp_t access_directory(req_t r);
		logic [5:0]        set_idx;
		logic [TAG_W-1:0]  tag;
		logic              is_write;
		logic              found;
		logic [OWAY_W-1:0] hit_way;
		logic [OWAY_W-1:0] victim;
		rsp_t              res;
		set_idx  = r.address[10:5];
		tag      = r.address[31:11];
		is_write = (r.opcode == OP_WRITE);
		found    = 1'b0;
		hit_way  = '0;
		res      = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (!found && dir_valid[set_idx][w] && dir_tag[set_idx][w] == tag) begin
				found   = 1'b1;
				hit_way = OWAY_W'(w);
			end
		end
		if (found) begin
			res.hit = 1'b1;
			res.way = hit_way;
			if (is_write)
				dir_dirty[set_idx][hit_way] = 1'b1;
		end else begin
			victim = fill_ptr[set_idx];
			if (dir_valid[set_idx][victim]) begin
				res.victim_tag   = dir_tag[set_idx][victim];
				res.victim_dirty = dir_dirty[set_idx][victim];
			end
			dir_tag[set_idx][victim]   = tag;
			dir_valid[set_idx][victim] = 1'b1;
			dir_dirty[set_idx][victim] = is_write;
			fill_ptr[set_idx] = (victim == OWAY_W'(WAYS - 1)) ? '0 : victim + 1'b1;
			res.way = victim;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SETS; s++) begin
				fill_ptr[s] = '0;
				for (int w = 0; w < WAYS; w++) begin
					dir_valid[s][w] = 1'b0;
					dir_dirty[s][w] = 1'b0;
				end
			end
			expected_q.delete();
			errors     = 0;
			pending    = 0;
			results    = 0;
			hits       = 0;
			writebacks = 0;
		end else begin
			if (valid) begin
				if (expected_q.size() == 0) begin
					$error("result with no transaction outstanding");
					errors++;
				end else begin
					want = expected_q.pop_front();
					results++;
					if (want.hit)
						hits++;
					if (want.victim_dirty)
						writebacks++;
					if (rsp.hit !== want.hit) begin
						$error("hit: expected %0d, got %0d", want.hit, rsp.hit);
						errors++;
					end
					if (rsp.way !== want.way) begin
						$error("way: expected %0d, got %0d", want.way, rsp.way);
						errors++;
					end
					if (rsp.victim_dirty !== want.victim_dirty) begin
						$error("victim_dirty: expected %0d, got %0d",
							want.victim_dirty, rsp.victim_dirty);
						errors++;
					end
					if (rsp.victim_tag !== want.victim_tag) begin
						$error("victim_tag: expected %h, got %h",
							want.victim_tag, rsp.victim_tag);
						errors++;
					end
				end
			end
			if (start && !busy)
				expected_q.push_back(access_directory(req));
			pending = expected_q.size();
		end
	end

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb import sacf_pkg::*; ();

	localparam int RANDOM_ACCESSES = 1500;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t req    = '0;
	logic busy;
	logic valid;
	rsp_t rsp;

	int errors;
	int pending;
	int results;
	int hits;
	int writebacks;
	int issued;

	logic [TAG_W-1:0] tag_pool [8];
	logic [5:0]       set_pool [4];

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	set_assoc_cache_fifo_lookup dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.valid  (valid),
		.rsp    (rsp)
	);

	sacf_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req        (req),
		.valid      (valid),
		.rsp        (rsp),
		.errors     (errors),
		.pending    (pending),
		.results    (results),
		.hits       (hits),
		.writebacks (writebacks)
	);

	// Presents one access, with random idle cycles ahead of it, and returns
	// at the edge where the transaction is taken.
	task automatic issue(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
		input bit may_idle);
		while (may_idle && $urandom_range(99) < 35) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req   <= '{opcode: op, address: addr};
		do begin
			@(posedge clk);
		end while (busy);
		issued++;
	endtask

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		logic [OP_W-1:0]   op;
		logic [ADDR_W-1:0] addr;
		int                drain;
		issued = 0;
		tag_pool[0] = '0;
		tag_pool[1] = '1;
		for (int i = 2; i < 8; i++)
			tag_pool[i] = TAG_W'($urandom);
		set_pool[0] = '0;
		set_pool[1] = '1;
		set_pool[2] = 6'($urandom);
		set_pool[3] = 6'($urandom);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Fill set 0 through all five ways, then keep missing so that clean,
		// dirty and written-on-hit lines are all replaced.
		issue(OP_READ,  32'h0000_0000, 1);
		issue(OP_READ,  32'h0000_001F, 1);
		issue(OP_WRITE, 32'hFFFF_FFFF, 1);
		issue(OP_READ,  32'hFFFF_FFE0, 1);
		issue(OP_FETCH, 32'h0000_0800, 1);
		issue(2'd3,     32'h0000_1000, 1);
		issue(OP_WRITE, 32'h0000_1004, 1);
		issue(OP_WRITE, 32'h0000_1800, 1);
		issue(OP_FETCH, 32'h0000_2000, 1);
		issue(OP_READ,  32'h0000_2800, 1);
		issue(OP_READ,  32'h0000_3000, 1);
		issue(OP_READ,  32'h0000_3800, 1);
		issue(OP_FETCH, 32'h0000_4000, 1);
		issue(2'd3,     32'h0000_2000, 1);
		issue(2'd3,     32'h0000_1000, 1);
		issue(OP_WRITE, 32'hAAAA_AAAA, 1);
		issue(OP_WRITE, 32'h5555_5555, 1);
		issue(OP_READ,  32'hAAAA_AAAA, 1);
		issue(OP_FETCH, 32'h7FFF_F7E0, 1);
		issue(OP_WRITE, 32'h8000_07E0, 1);

		// Mostly a small working set so that hits and evictions are frequent.
		for (int i = 0; i < RANDOM_ACCESSES; i++) begin
			op = OP_W'($urandom_range(3));
			if ($urandom_range(99) < 75)
				addr = {tag_pool[$urandom_range(7)], set_pool[$urandom_range(3)],
					5'($urandom)};
			else
				addr = $urandom;
			issue(op, addr, !(i >= 500 && i < 800));
		end
		start <= 1'b0;

		drain = 0;
		while (pending != 0 && drain < 1000) begin
			@(posedge clk);
			drain++;
		end
		repeat (8) @(posedge clk);

		$display("Issued %0d accesses; %0d results checked, %0d hits, %0d dirty evictions.",
			issued, results, hits, writebacks);
		if (errors == 0 && pending == 0 && results == issued)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> files.f
sv/sacf_pkg.sv
sv/sacf_dir_mem.sv
sv/sacf_way_logic.sv
sv/set_assoc_cache_fifo_lookup.sv
test/sacf_checker.sv
test/tb.sv
